// ===== hw/rtl/dmg_pkg.sv =====
// Shared types, constants and helper functions of the sound unit.
`timescale 1ns / 1ps
package dmg_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_CPU_CLOCK   = 2'd1;

  localparam logic [16:0] SAMPLE_RATE_RST = 17'd48000;
  localparam logic [23:0] CPU_CLOCK_RST   = 24'd4194304;

  // register index = address - FF10
  localparam logic [5:0] IDX_NR10 = 6'h00;
  localparam logic [5:0] IDX_NR11 = 6'h01;
  localparam logic [5:0] IDX_NR12 = 6'h02;
  localparam logic [5:0] IDX_NR13 = 6'h03;
  localparam logic [5:0] IDX_NR14 = 6'h04;
  localparam logic [5:0] IDX_NR21 = 6'h06;
  localparam logic [5:0] IDX_NR22 = 6'h07;
  localparam logic [5:0] IDX_NR23 = 6'h08;
  localparam logic [5:0] IDX_NR24 = 6'h09;
  localparam logic [5:0] IDX_NR30 = 6'h0A;
  localparam logic [5:0] IDX_NR31 = 6'h0B;
  localparam logic [5:0] IDX_NR32 = 6'h0C;
  localparam logic [5:0] IDX_NR33 = 6'h0D;
  localparam logic [5:0] IDX_NR34 = 6'h0E;
  localparam logic [5:0] IDX_NR41 = 6'h10;
  localparam logic [5:0] IDX_NR42 = 6'h11;
  localparam logic [5:0] IDX_NR43 = 6'h12;
  localparam logic [5:0] IDX_NR44 = 6'h13;
  localparam logic [5:0] IDX_NR50 = 6'h14;
  localparam logic [5:0] IDX_NR51 = 6'h15;
  localparam logic [5:0] IDX_NR52 = 6'h16;

  localparam logic [5:0] IDX_PULSE_LEN [2] = '{IDX_NR11, IDX_NR21};
  localparam logic [5:0] IDX_PULSE_ENV [2] = '{IDX_NR12, IDX_NR22};
  localparam logic [5:0] IDX_PULSE_LO  [2] = '{IDX_NR13, IDX_NR23};
  localparam logic [5:0] IDX_PULSE_HI  [2] = '{IDX_NR14, IDX_NR24};

  localparam int unsigned NUM_REGS = 48;
  localparam int unsigned NUM_WAVE = 16;

  localparam logic [7:0] STATUS_MASK = 8'h70;

  localparam logic [7:0] READ_MASK [NUM_REGS] = '{
    8'h80, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00, 8'hFF, 8'hBF,
    8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hBF,
    8'h00, 8'h00, 8'h70, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  localparam logic [7:0] DUTY_WAVE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};
  localparam logic [6:0] NOISE_BASE [8] = '{7'd8, 7'd16, 7'd32, 7'd48,
                                            7'd64, 7'd80, 7'd96, 7'd112};

  localparam logic [32:0] SAMPLE_MAX = 33'd32767;
  localparam logic [23:0] SUM_MAX    = 24'hFFFFFF;

  typedef struct packed {
    logic capture;
    logic bus_write;
    logic bus_read;
    logic tick_a;
    logic tick_c;
    logic div_start;
    logic div_right;
    logic cap_left;
    logic cap_right;
    logic mul;
    logic load_read;
    logic load_samp;
  } dmg_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_busy;
  } dmg_stat_t;

  // {overflow, period}
  function automatic logic [11:0] sweep_calc(input logic [10:0] sh, input logic [6:0] set);
    logic [10:0] delta;
    delta = sh >> set[2:0];
    return set[3] ? ({1'b0, sh} - {1'b0, delta}) : ({1'b0, sh} + {1'b0, delta});
  endfunction

  function automatic logic [22:0] noise_reload(input logic [7:0] ns);
    return {16'd0, NOISE_BASE[ns[2:0]]} << ns[7:4];
  endfunction

  function automatic logic [13:0] pulse_reload(input logic [10:0] p);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, p};
    return {d, 2'b00};
  endfunction

  function automatic logic [12:0] wave_reload(input logic [10:0] p);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, p};
    return {d, 1'b0};
  endfunction

  function automatic logic [8:0] vol_scale(input logic [2:0] v);
    logic [8:0] f;
    f = {6'd0, v} + 9'd1;
    return f * 9'd46;
  endfunction

endpackage

// ===== hw/rtl/dmg_if.sv =====
// Handshake channel interfaces for bus items and result items.
`timescale 1ns / 1ps
interface dmg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  write_data;
  modport source (output valid, kind, address, write_data, input ready);
  modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface dmg_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         read_data;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  modport source (output valid, result_kind, read_data, left_sample, right_sample,
                  input ready);
  modport sink   (input valid, result_kind, read_data, left_sample, right_sample,
                  output ready);
endinterface

// ===== hw/rtl/dmg_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dmg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [23:0] quotient_o
);
  localparam logic [4:0] STEPS = 5'd24;

  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [23:0] quo_q, quo_d;
  logic [16:0] rem_sh;

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    rem_sh = {rem_q[15:0], quo_q[23]};
    if (start_i) begin
      cnt_d = STEPS;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (rem_sh >= {1'b0, divisor_i}) begin
        rem_d = rem_sh - {1'b0, divisor_i};
        quo_d = {quo_q[22:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = cnt_q != 5'd0;
  assign quotient_o = quo_q;
endmodule

// ===== hw/rtl/dmg_ctrl.sv =====
// Sequencer that steps the datapath through reads, writes, ticks and samples.
`timescale 1ns / 1ps
module dmg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_kind_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  dmg_pkg::dmg_stat_t stat_i,
  output dmg_pkg::dmg_cmd_t  cmd_o
);
  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_WRITE  = 13'b0000000000010,
    ST_READ   = 13'b0000000000100,
    ST_RD_OUT = 13'b0000000001000,
    ST_TICK_A = 13'b0000000010000,
    ST_TICK_B = 13'b0000000100000,
    ST_TICK_C = 13'b0000001000000,
    ST_DIV_L  = 13'b0000010000000,
    ST_WAIT_L = 13'b0000100000000,
    ST_DIV_R  = 13'b0001000000000,
    ST_WAIT_R = 13'b0010000000000,
    ST_MUL    = 13'b0100000000000,
    ST_SM_OUT = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_kind_i)
            dmg_pkg::KIND_TICK:  state_d = ST_TICK_A;
            dmg_pkg::KIND_READ:  state_d = ST_READ;
            dmg_pkg::KIND_WRITE: state_d = ST_WRITE;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        cmd_o.bus_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        cmd_o.bus_read = 1'b1;
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          cmd_o.load_read = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TICK_A: begin
        cmd_o.tick_a = 1'b1;
        state_d = ST_TICK_B;
      end
      ST_TICK_B: state_d = ST_TICK_C;
      ST_TICK_C: begin
        cmd_o.tick_c = 1'b1;
        state_d = stat_i.emit ? ST_DIV_L : ST_IDLE;
      end
      ST_DIV_L: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_WAIT_L;
      end
      ST_WAIT_L: begin
        if (!stat_i.div_busy) begin
          cmd_o.cap_left = 1'b1;
          state_d = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_right = 1'b1;
        state_d = ST_WAIT_R;
      end
      ST_WAIT_R: begin
        cmd_o.div_right = 1'b1;
        if (!stat_i.div_busy) begin
          cmd_o.cap_right = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_SM_OUT;
      end
      ST_SM_OUT: begin
        if (out_free) begin
          cmd_o.load_samp = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_read || cmd_o.load_samp) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== hw/rtl/dmg_datapath.sv =====
// Channel state, register file, wave RAM, mixer and output registers.
`timescale 1ns / 1ps
module dmg_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmg_pkg::dmg_cmd_t  cmd_i,
  output logic              emit_o,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  output logic [23:0]       div_dividend_o,
  output logic [15:0]       div_divisor_o,
  input  logic [23:0]       div_quotient_i,
  output logic              result_kind_o,
  output logic [7:0]        read_data_o,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o
);
  // captured bus item
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;

  // channel and sequencer state
  logic        power_q, power_d;
  logic [3:0]  active_q, active_d, conv_q, conv_d, gate_q, gate_d;
  logic [8:0]  len_q [4];
  logic [8:0]  len_d [4];
  logic [22:0] timer_q [4];
  logic [22:0] timer_d [4];
  logic [10:0] tone_q [3];
  logic [10:0] tone_d [3];
  logic [1:0]  dsel_q [2];
  logic [1:0]  dsel_d [2];
  logic [2:0]  dstep_q [2];
  logic [2:0]  dstep_d [2];
  logic [3:0]  elvl_q [3];
  logic [3:0]  elvl_d [3];
  logic [3:0]  estart_q [3];
  logic [3:0]  estart_d [3];
  logic [2:0]  erise_q, erise_d;
  logic [2:0]  epace_q [3];
  logic [2:0]  epace_d [3];
  logic [3:0]  ecnt_q [3];
  logic [3:0]  ecnt_d [3];
  logic [6:0]  swset_q, swset_d;
  logic [3:0]  swcnt_q, swcnt_d;
  logic [10:0] swsh_q, swsh_d;
  logic        swrun_q, swrun_d;
  logic [4:0]  wpos_q, wpos_d;
  logic [1:0]  wlvl_q, wlvl_d;
  logic [14:0] lfsr_q, lfsr_d;
  logic [7:0]  nset_q, nset_d;
  logic [12:0] seqc_q, seqc_d;
  logic [2:0]  seqs_q, seqs_d;
  logic [23:0] phase_q, phase_d, lsum_q, lsum_d, rsum_q, rsum_d;
  logic [15:0] tcnt_q, tcnt_d;
  logic [7:0]  route_q, route_d, mvol_q, mvol_d;
  logic [16:0] rate_q;
  logic [23:0] cpu_q;
  logic [47:0] sval_q, sval_d;
  logic [15:0] wval_q, wval_d;

  // memories
  logic [7:0]  shadow_mem [dmg_pkg::NUM_REGS];
  logic [7:0]  wave_mem [dmg_pkg::NUM_WAVE];
  logic [7:0]  sh_rd_q, wa_rd_q, wb_rd_q;

  // datapath results
  logic [23:0] quo_l_q, quo_r_q;
  logic [32:0] prod_l_q, prod_r_q;
  logic        res_kind_q;
  logic [7:0]  rdata_q;
  logic [15:0] lsamp_q, rsamp_q;

  logic        in_range, is_wave, wr_ok;
  logic [5:0]  idx;

  assign in_range = (addr_q[15:6] == 10'h3FC) && (addr_q[5:4] != 2'd0);
  assign idx      = addr_q[5:0] - 6'h10;
  assign is_wave  = addr_q[5:4] == 2'd3;
  assign wr_ok    = cmd_i.bus_write && in_range && (idx != dmg_pkg::IDX_NR52)
                    && (power_q || is_wave);

  always_comb begin
    logic [7:0]  v;
    logic [10:0] tn;
    logic [11:0] sw;
    logic [23:0] t;
    logic [13:0] sc;
    logic        b;
    logic [14:0] s2;
    logic [3:0]  lv [4];
    logic [7:0]  byte_v;
    logic [3:0]  nib;
    logic [5:0]  l, r;
    logic [24:0] ls, rs, p;

    v = wdata_q;
    tn = '0; sw = '0; t = '0; sc = '0; b = 1'b0; s2 = '0;
    byte_v = '0; nib = '0; l = '0; r = '0; ls = '0; rs = '0; p = '0;
    for (int c = 0; c < 4; c++) lv[c] = '0;

    power_d = power_q; active_d = active_q; conv_d = conv_q; gate_d = gate_q;
    len_d = len_q; timer_d = timer_q; tone_d = tone_q; dsel_d = dsel_q;
    dstep_d = dstep_q; elvl_d = elvl_q; estart_d = estart_q; erise_d = erise_q;
    epace_d = epace_q; ecnt_d = ecnt_q; swset_d = swset_q; swcnt_d = swcnt_q;
    swsh_d = swsh_q; swrun_d = swrun_q; wpos_d = wpos_q; wlvl_d = wlvl_q;
    lfsr_d = lfsr_q; nset_d = nset_q; seqc_d = seqc_q; seqs_d = seqs_q;
    phase_d = phase_q; lsum_d = lsum_q; rsum_d = rsum_q; tcnt_d = tcnt_q;
    route_d = route_q; mvol_d = mvol_q; sval_d = sval_q; wval_d = wval_q;
    emit_o = 1'b0;

    // power register: switching off wipes the channel state but not the wave RAM or the rates
    if (cmd_i.bus_write && in_range && idx == dmg_pkg::IDX_NR52) begin
      if (!v[7] && power_q) begin
        active_d = '0; conv_d = '0; gate_d = '0; erise_d = '0;
        for (int c = 0; c < 4; c++) begin
          len_d[c] = '0;
          timer_d[c] = '0;
        end
        for (int c = 0; c < 3; c++) begin
          tone_d[c] = '0; elvl_d[c] = '0; estart_d[c] = '0;
          epace_d[c] = '0; ecnt_d[c] = '0;
        end
        for (int c = 0; c < 2; c++) begin
          dsel_d[c] = '0;
          dstep_d[c] = '0;
        end
        swset_d = '0; swcnt_d = '0; swsh_d = '0; swrun_d = 1'b0;
        wpos_d = '0; wlvl_d = '0; lfsr_d = '0; nset_d = '0;
        seqc_d = '0; seqs_d = '0; phase_d = '0; lsum_d = '0; rsum_d = '0;
        tcnt_d = '0; route_d = '0; mvol_d = '0; sval_d = '0;
      end
      power_d = v[7];
    end

    if (wr_ok) begin
      if (is_wave) wval_d[addr_q[3:0]] = 1'b1;
      else sval_d[idx] = 1'b1;

      for (int c = 0; c < 2; c++) begin
        if (idx == dmg_pkg::IDX_PULSE_LEN[c]) begin
          dsel_d[c] = v[7:6];
          len_d[c] = 9'd64 - {3'd0, v[5:0]};
        end
        if (idx == dmg_pkg::IDX_PULSE_ENV[c]) begin
          estart_d[c] = v[7:4];
          erise_d[c]  = v[3];
          epace_d[c]  = v[2:0];
          conv_d[c]   = v[7:3] != 5'd0;
          if (v[7:3] == 5'd0) active_d[c] = 1'b0;
        end
        if (idx == dmg_pkg::IDX_PULSE_LO[c]) tone_d[c] = {tone_q[c][10:8], v};
        if (idx == dmg_pkg::IDX_PULSE_HI[c]) begin
          tn = {v[2:0], tone_q[c][7:0]};
          tone_d[c] = tn;
          gate_d[c] = v[6];
          if (v[7]) begin
            active_d[c] = conv_q[c];
            timer_d[c]  = {9'd0, dmg_pkg::pulse_reload(tn)};
            elvl_d[c]   = estart_q[c];
            ecnt_d[c]   = {1'b0, epace_q[c]};
            if (len_q[c] == 9'd0) len_d[c] = 9'd64;
            if (c == 0) begin
              swsh_d  = tn;
              swcnt_d = (swset_q[6:4] != 3'd0) ? {1'b0, swset_q[6:4]} : 4'd8;
              swrun_d = swset_q[6:4] != 3'd0 || swset_q[2:0] != 3'd0;
              sw = dmg_pkg::sweep_calc(tn, swset_q);
              if (swset_q[2:0] != 3'd0 && sw[11]) active_d[0] = 1'b0;
            end
          end
        end
      end

      unique case (idx)
        dmg_pkg::IDX_NR10: swset_d = v[6:0];
        dmg_pkg::IDX_NR30: begin
          conv_d[2] = v[7];
          if (!v[7]) active_d[2] = 1'b0;
        end
        dmg_pkg::IDX_NR31: len_d[2] = 9'd256 - {1'b0, v};
        dmg_pkg::IDX_NR32: wlvl_d = v[6:5];
        dmg_pkg::IDX_NR33: tone_d[2] = {tone_q[2][10:8], v};
        dmg_pkg::IDX_NR34: begin
          tn = {v[2:0], tone_q[2][7:0]};
          tone_d[2] = tn;
          gate_d[2] = v[6];
          if (v[7]) begin
            active_d[2] = conv_q[2];
            timer_d[2]  = {10'd0, dmg_pkg::wave_reload(tn)};
            wpos_d = '0;
            if (len_q[2] == 9'd0) len_d[2] = 9'd256;
          end
        end
        dmg_pkg::IDX_NR41: len_d[3] = 9'd64 - {3'd0, v[5:0]};
        dmg_pkg::IDX_NR42: begin
          estart_d[2] = v[7:4];
          erise_d[2]  = v[3];
          epace_d[2]  = v[2:0];
          conv_d[3]   = v[7:3] != 5'd0;
          if (v[7:3] == 5'd0) active_d[3] = 1'b0;
        end
        dmg_pkg::IDX_NR43: nset_d = v;
        dmg_pkg::IDX_NR44: begin
          gate_d[3] = v[6];
          if (v[7]) begin
            active_d[3] = conv_q[3];
            timer_d[3]  = dmg_pkg::noise_reload(nset_q);
            elvl_d[2]   = estart_q[2];
            ecnt_d[2]   = {1'b0, epace_q[2]};
            lfsr_d      = 15'h7FFF;
            if (len_q[3] == 9'd0) len_d[3] = 9'd64;
          end
        end
        dmg_pkg::IDX_NR50: mvol_d = v;
        dmg_pkg::IDX_NR51: route_d = v;
        default: ;
      endcase
    end

    // tick, first half: timers, LFSR and frame sequencer
    if (cmd_i.tick_a && power_q) begin
      for (int c = 0; c < 2; c++) begin
        t = {1'b0, timer_q[c]} - 24'd2;
        if (t[23] || t == 24'd0) begin
          t = t + {10'd0, dmg_pkg::pulse_reload(tone_q[c])};
          dstep_d[c] = dstep_q[c] + 3'd1;
        end
        timer_d[c] = t[22:0];
      end
      t = {1'b0, timer_q[2]} - 24'd2;
      if (t[23] || t == 24'd0) begin
        t = t + {11'd0, dmg_pkg::wave_reload(tone_q[2])};
        wpos_d = wpos_q + 5'd1;
      end
      timer_d[2] = t[22:0];
      t = {1'b0, timer_q[3]} - 24'd2;
      if (t[23] || t == 24'd0) begin
        t = t + {1'b0, dmg_pkg::noise_reload(nset_q)};
        b  = lfsr_q[0] ^ lfsr_q[1];
        s2 = {b, lfsr_q[14:1]};
        if (nset_q[3]) s2[6] = b;
        lfsr_d = s2;
      end
      timer_d[3] = t[22:0];

      sc = {1'b0, seqc_q} + 14'd2;
      seqc_d = sc[12:0];
      if (sc[13]) begin
        seqs_d = seqs_q + 3'd1;
        if (seqs_q[0] == 1'b0) begin
          // length counters on every even step
          for (int c = 0; c < 4; c++) begin
            if (gate_q[c] && len_q[c] != 9'd0) begin
              len_d[c] = len_q[c] - 9'd1;
              if (len_q[c] == 9'd1) active_d[c] = 1'b0;
            end
          end
          if (seqs_q[1]) begin
            if (swcnt_q > 4'd1) begin
              swcnt_d = swcnt_q - 4'd1;
            end else begin
              swcnt_d = (swset_q[6:4] != 3'd0) ? {1'b0, swset_q[6:4]} : 4'd8;
              if (swrun_q && swset_q[6:4] != 3'd0) begin
                sw = dmg_pkg::sweep_calc(swsh_q, swset_q);
                if (sw[11]) begin
                  active_d[0] = 1'b0;
                end else if (swset_q[2:0] != 3'd0) begin
                  swsh_d    = sw[10:0];
                  tone_d[0] = sw[10:0];
                  sw = dmg_pkg::sweep_calc(sw[10:0], swset_q);
                  if (sw[11]) active_d[0] = 1'b0;
                end
              end
            end
          end
        end else if (seqs_q == 3'd7) begin
          for (int e = 0; e < 3; e++) begin
            if (epace_q[e] != 3'd0) begin
              if (ecnt_q[e] > 4'd1) begin
                ecnt_d[e] = ecnt_q[e] - 4'd1;
              end else begin
                ecnt_d[e] = {1'b0, epace_q[e]};
                if (erise_q[e] && elvl_q[e] != 4'd15) elvl_d[e] = elvl_q[e] + 4'd1;
                else if (!erise_q[e] && elvl_q[e] != 4'd0) elvl_d[e] = elvl_q[e] - 4'd1;
              end
            end
          end
        end
      end
    end

    // tick, second half: mix, accumulate, advance the sample phase
    if (cmd_i.tick_c) begin
      if (power_q) begin
        for (int c = 0; c < 2; c++) begin
          if (active_q[c] && conv_q[c] && dmg_pkg::DUTY_WAVE[dsel_q[c]][dstep_q[c]])
            lv[c] = elvl_q[c];
        end
        if (active_q[2] && conv_q[2] && wlvl_q != 2'd0) begin
          byte_v = wval_q[wpos_q[4:1]] ? wb_rd_q : 8'h00;
          nib = wpos_q[0] ? byte_v[3:0] : byte_v[7:4];
          lv[2] = nib >> (wlvl_q - 2'd1);
        end
        if (active_q[3] && conv_q[3] && !lfsr_q[0]) lv[3] = elvl_q[2];
        for (int c = 0; c < 4; c++) begin
          if (route_q[4 + c]) l = l + {2'd0, lv[c]};
          if (route_q[c])     r = r + {2'd0, lv[c]};
        end
        ls = {1'b0, lsum_q} + {19'd0, l};
        rs = {1'b0, rsum_q} + {19'd0, r};
        lsum_d = ls[24] ? SUM_MAX_C : ls[23:0];
        rsum_d = rs[24] ? SUM_MAX_C : rs[23:0];
      end
      if (tcnt_q != 16'hFFFF) tcnt_d = tcnt_q + 16'd1;
      p = {1'b0, phase_q} + {7'd0, rate_q, 1'b0};
      emit_o = p >= {1'b0, cpu_q};
      if (emit_o) p = p - {1'b0, cpu_q};
      phase_d = p[24] ? SUM_MAX_C : p[23:0];
    end

    if (cmd_i.load_samp) begin
      lsum_d = '0;
      rsum_d = '0;
      tcnt_d = '0;
    end
  end

  localparam logic [23:0] SUM_MAX_C = dmg_pkg::SUM_MAX;

  assign div_dividend_o = cmd_i.div_right ? rsum_q : lsum_q;
  assign div_divisor_o  = tcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= 1'b1; active_q <= '0; conv_q <= '0; gate_q <= '0; erise_q <= '0;
      for (int c = 0; c < 4; c++) begin
        len_q[c] <= '0;
        timer_q[c] <= '0;
      end
      for (int c = 0; c < 3; c++) begin
        tone_q[c] <= '0; elvl_q[c] <= '0; estart_q[c] <= '0;
        epace_q[c] <= '0; ecnt_q[c] <= '0;
      end
      for (int c = 0; c < 2; c++) begin
        dsel_q[c] <= '0;
        dstep_q[c] <= '0;
      end
      swset_q <= '0; swcnt_q <= '0; swsh_q <= '0; swrun_q <= 1'b0;
      wpos_q <= '0; wlvl_q <= '0; lfsr_q <= '0; nset_q <= '0;
      seqc_q <= '0; seqs_q <= '0; phase_q <= '0; lsum_q <= '0; rsum_q <= '0;
      tcnt_q <= '0; route_q <= '0; mvol_q <= '0; sval_q <= '0; wval_q <= '0;
      rate_q <= dmg_pkg::SAMPLE_RATE_RST;
      cpu_q  <= dmg_pkg::CPU_CLOCK_RST;
    end else begin
      power_q <= power_d; active_q <= active_d; conv_q <= conv_d; gate_q <= gate_d;
      erise_q <= erise_d; len_q <= len_d; timer_q <= timer_d; tone_q <= tone_d;
      elvl_q <= elvl_d; estart_q <= estart_d; epace_q <= epace_d; ecnt_q <= ecnt_d;
      dsel_q <= dsel_d; dstep_q <= dstep_d;
      swset_q <= swset_d; swcnt_q <= swcnt_d; swsh_q <= swsh_d; swrun_q <= swrun_d;
      wpos_q <= wpos_d; wlvl_q <= wlvl_d; lfsr_q <= lfsr_d; nset_q <= nset_d;
      seqc_q <= seqc_d; seqs_q <= seqs_d; phase_q <= phase_d;
      lsum_q <= lsum_d; rsum_q <= rsum_d; tcnt_q <= tcnt_d;
      route_q <= route_d; mvol_q <= mvol_d; sval_q <= sval_d; wval_q <= wval_d;
      if (cfg_we_i) begin
        if (cfg_index_i == dmg_pkg::CFG_SAMPLE_RATE) rate_q <= cfg_data_i[16:0];
        else if (cfg_index_i == dmg_pkg::CFG_CPU_CLOCK) cpu_q <= cfg_data_i;
      end
    end
  end

  // register file and wave RAM
  always_ff @(posedge clk_i) begin
    if (wr_ok && !is_wave) shadow_mem[idx] <= wdata_q;
    if (cmd_i.bus_read && in_range && !is_wave) sh_rd_q <= shadow_mem[idx];
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok && is_wave) wave_mem[addr_q[3:0]] <= wdata_q;
    wa_rd_q <= wave_mem[addr_q[3:0]];
    wb_rd_q <= wave_mem[wpos_q[4:1]];
  end

  // item capture, quotients, products and the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.cap_left)  quo_l_q <= div_quotient_i;
    if (cmd_i.cap_right) quo_r_q <= div_quotient_i;
    if (cmd_i.mul) begin
      prod_l_q <= {9'd0, quo_l_q} * {24'd0, dmg_pkg::vol_scale(mvol_q[6:4])};
      prod_r_q <= {9'd0, quo_r_q} * {24'd0, dmg_pkg::vol_scale(mvol_q[2:0])};
    end
    if (cmd_i.load_read) begin
      res_kind_q <= 1'b0;
      lsamp_q <= '0;
      rsamp_q <= '0;
      if (!in_range) rdata_q <= 8'hFF;
      else if (is_wave) rdata_q <= wval_q[addr_q[3:0]] ? wa_rd_q : 8'h00;
      else if (idx == dmg_pkg::IDX_NR52) rdata_q <= {power_q, 3'd0, active_q}
                                                    | dmg_pkg::STATUS_MASK;
      else rdata_q <= (sval_q[idx] ? sh_rd_q : 8'h00) | dmg_pkg::READ_MASK[idx];
    end
    if (cmd_i.load_samp) begin
      res_kind_q <= 1'b1;
      rdata_q <= '0;
      lsamp_q <= (prod_l_q > dmg_pkg::SAMPLE_MAX) ? 16'h7FFF : prod_l_q[15:0];
      rsamp_q <= (prod_r_q > dmg_pkg::SAMPLE_MAX) ? 16'h7FFF : prod_r_q[15:0];
    end
  end

  assign result_kind_o  = res_kind_q;
  assign read_data_o    = rdata_q;
  assign left_sample_o  = lsamp_q;
  assign right_sample_o = rsamp_q;
endmodule

// ===== hw/rtl/dmg_sound_unit_emulation.sv =====
// Top level of the four-channel handheld sound unit.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries bus items: kind (source clock tick, register read,
//   register write), address and write_data. out_ch carries result items:
//   read data for every read, and a stereo sample when the output phase
//   accumulator wraps on a tick. cfg_* writes the sample rate (index 0) and
//   the source clock rate (index 1); it is always ready. The user writes it
//   only while the block is idle; the block itself does not enforce this.
//   Steps per item, set by the controller sequence: a write goes idle after
//     its write state; a read loads a registered register-file read; a tick
//     without a sample runs timers, a wave RAM read and the mix; a tick with
//     a sample is dominated by two passes of the shared serial divider
//     that averages each side over the ticks since the last sample.
//   A finished result sits in the output register; the next item is accepted
//   while it waits. An item that needs the output register while it is still
//   full holds in its last state until the receiver takes the pending one.
//   Reset: power on, all channel state and the register file zero, wave RAM
//   reading zero until written, rates at their defaults. No clearing pass.
module dmg_sound_unit_emulation (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmg_in_if.sink      in_ch,
  dmg_out_if.source   out_ch,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  dmg_pkg::dmg_cmd_t  cmd;
  dmg_pkg::dmg_stat_t stat;
  logic [23:0] div_dividend, div_quotient;
  logic [15:0] div_divisor;
  logic        emit;
  logic        div_busy;

  // config port never stalls
  assign cfg_ready_o = 1'b1;

  assign stat.emit     = emit;
  assign stat.div_busy = div_busy;

  dmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_kind_i   (in_ch.kind),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dmg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .emit_o         (emit),
    .address_i      (in_ch.address),
    .write_data_i   (in_ch.write_data),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_quotient_i (div_quotient),
    .result_kind_o  (out_ch.result_kind),
    .read_data_o    (out_ch.read_data),
    .left_sample_o  (out_ch.left_sample),
    .right_sample_o (out_ch.right_sample)
  );

  // shared averaging divider: left side first, then right
  dmg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quotient)
  );
endmodule

// ===== tb/dmg_sound_unit_emulation_checker.sv =====
// Result checker of the sound unit: watches all channels, predicts and compares.
`timescale 1ns / 1ps
module dmg_sound_unit_emulation_checker
  import dmg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dmg_in_if           in_ch,
  dmg_out_if          out_ch,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic               is_sample;
    logic [7:0]         rd;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } apu_result_t;

  apu_result_t result_q[$];
  int          fails;

  logic [16:0] out_rate;
  logic [23:0] clk_rate;
  logic [7:0]  regs [NUM_REGS];
  logic [7:0]  wram [NUM_WAVE];
  logic        pwr;
  logic        active [4];
  logic        dac [4];
  logic        len_en [4];
  int          len_cnt [4];
  int          ftimer [4];
  logic [10:0] period [3];
  logic [1:0]  duty_sel [2];
  logic [2:0]  duty_pos [2];
  logic [3:0]  env_lvl [3];
  logic [3:0]  env_init [3];
  logic        env_up [3];
  logic [2:0]  env_pace [3];
  logic [3:0]  env_cnt [3];
  logic [6:0]  sweep_cfg;
  logic [3:0]  sweep_cnt;
  logic [10:0] sweep_sh;
  logic        sweep_en;
  logic [4:0]  wave_pos;
  logic [1:0]  wave_vol;
  logic [14:0] lfsr;
  logic [7:0]  noise_cfg;
  int          seq_cnt;
  logic [2:0]  seq_step;
  longint      phase;
  longint      lsum, rsum;
  int          ticks;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic void clear_core();
    for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
    pwr = 1'b1;
    for (int c = 0; c < 4; c++) begin
      active[c] = 0; dac[c] = 0; len_en[c] = 0; len_cnt[c] = 0; ftimer[c] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      period[c] = '0; env_lvl[c] = '0; env_init[c] = '0;
      env_up[c] = 0; env_pace[c] = '0; env_cnt[c] = '0;
    end
    for (int c = 0; c < 2; c++) begin
      duty_sel[c] = '0; duty_pos[c] = '0;
    end
    sweep_cfg = '0; sweep_cnt = '0; sweep_sh = '0; sweep_en = 0;
    wave_pos = '0; wave_vol = '0; lfsr = '0; noise_cfg = '0;
    seq_cnt = 0; seq_step = '0; phase = 0; lsum = 0; rsum = 0; ticks = 0;
  endfunction

  // {overflow, next period}
  function automatic logic [11:0] sweep_target();
    logic [11:0] d;
    d = {1'b0, sweep_sh} >> sweep_cfg[2:0];
    return sweep_cfg[3] ? {1'b0, sweep_sh} - d : {1'b0, sweep_sh} + d;
  endfunction

  function automatic int noise_period();
    int b;
    case (noise_cfg[2:0])
      3'd0: b = 8;
      default: b = 16 * noise_cfg[2:0];
    endcase
    return b << noise_cfg[7:4];
  endfunction

  function automatic void env_write(int e, int ch, logic [7:0] v);
    env_init[e] = v[7:4];
    env_up[e]   = v[3];
    env_pace[e] = v[2:0];
    dac[ch]     = v[7:3] != 0;
    if (!dac[ch]) active[ch] = 0;
  endfunction

  function automatic void trigger(int ch);
    logic [11:0] t;
    active[ch] = dac[ch];
    if (ch < 2) begin
      ftimer[ch] = (2048 - period[ch]) * 4;
      env_lvl[ch] = env_init[ch];
      env_cnt[ch] = env_pace[ch];
      if (len_cnt[ch] == 0) len_cnt[ch] = 64;
    end else if (ch == 2) begin
      ftimer[2] = (2048 - period[2]) * 2;
      wave_pos = '0;
      if (len_cnt[2] == 0) len_cnt[2] = 256;
    end else begin
      ftimer[3] = noise_period();
      env_lvl[2] = env_init[2];
      env_cnt[2] = env_pace[2];
      lfsr = 15'h7FFF;
      if (len_cnt[3] == 0) len_cnt[3] = 64;
    end
    if (ch == 0) begin
      sweep_sh  = period[0];
      sweep_cnt = sweep_cfg[6:4] != 0 ? {1'b0, sweep_cfg[6:4]} : 4'd8;
      sweep_en  = sweep_cfg[6:4] != 0 || sweep_cfg[2:0] != 0;
      if (sweep_cfg[2:0] != 0) begin
        t = sweep_target();
        if (t > 2047) active[0] = 0;
      end
    end
  endfunction

  function automatic void period_hi(int ch, logic [7:0] v);
    period[ch][10:8] = v[2:0];
    len_en[ch] = v[6];
    if (v[7]) trigger(ch);
  endfunction

  function automatic void reg_write(logic [15:0] a, logic [7:0] v);
    int i;
    if (a < 16'hFF10 || a > 16'hFF3F) return;
    i = a - 16'hFF10;
    if (i == IDX_NR52) begin
      if (!v[7] && pwr) clear_core();
      pwr = v[7];
      regs[i] = {v[7], 7'd0};
      return;
    end
    if (!pwr && i < 32) return;
    regs[i] = v;
    if (i >= 32) begin
      wram[i - 32] = v;
      return;
    end
    case (i[5:0])
      IDX_NR10: sweep_cfg = v[6:0];
      IDX_NR11, IDX_NR21: begin
        duty_sel[i == IDX_NR21] = v[7:6];
        len_cnt[i == IDX_NR21]  = 64 - v[5:0];
      end
      IDX_NR12: env_write(0, 0, v);
      IDX_NR22: env_write(1, 1, v);
      IDX_NR42: env_write(2, 3, v);
      IDX_NR13: period[0][7:0] = v;
      IDX_NR23: period[1][7:0] = v;
      IDX_NR33: period[2][7:0] = v;
      IDX_NR14: period_hi(0, v);
      IDX_NR24: period_hi(1, v);
      IDX_NR34: period_hi(2, v);
      IDX_NR30: begin
        dac[2] = v[7];
        if (!v[7]) active[2] = 0;
      end
      IDX_NR31: len_cnt[2] = 256 - v;
      IDX_NR32: wave_vol = v[6:5];
      IDX_NR41: len_cnt[3] = 64 - v[5:0];
      IDX_NR43: noise_cfg = v;
      IDX_NR44: begin
        len_en[3] = v[6];
        if (v[7]) trigger(3);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] reg_read(logic [15:0] a);
    int i;
    logic [7:0] v;
    if (a < 16'hFF10 || a > 16'hFF3F) return 8'hFF;
    if (a >= 16'hFF30) return wram[a - 16'hFF30];
    i = a - 16'hFF10;
    if (i == IDX_NR52) begin
      v = {pwr, 3'd0, active[3], active[2], active[1], active[0]};
      return v | READ_MASK[i];
    end
    return regs[i] | READ_MASK[i];
  endfunction

  function automatic void length_tick();
    for (int c = 0; c < 4; c++)
      if (len_en[c] && len_cnt[c] > 0) begin
        len_cnt[c]--;
        if (len_cnt[c] == 0) active[c] = 0;
      end
  endfunction

  function automatic void sweep_tick();
    logic [11:0] t;
    if (sweep_cnt > 1) begin
      sweep_cnt--;
      return;
    end
    sweep_cnt = sweep_cfg[6:4] != 0 ? {1'b0, sweep_cfg[6:4]} : 4'd8;
    if (!sweep_en || sweep_cfg[6:4] == 0) return;
    t = sweep_target();
    if (t > 2047) begin
      active[0] = 0;
      return;
    end
    if (sweep_cfg[2:0] != 0) begin
      sweep_sh  = t[10:0];
      period[0] = t[10:0];
      t = sweep_target();
      if (t > 2047) active[0] = 0;
    end
  endfunction

  function automatic void envelope_tick();
    for (int e = 0; e < 3; e++) begin
      if (env_pace[e] == 0) continue;
      if (env_cnt[e] > 1) begin
        env_cnt[e]--;
        continue;
      end
      env_cnt[e] = env_pace[e];
      if (env_up[e] && env_lvl[e] < 15) env_lvl[e]++;
      else if (!env_up[e] && env_lvl[e] > 0) env_lvl[e]--;
    end
  endfunction

  // Advance all channel timers for a tick item and accumulate the mixed levels.
  function automatic void run_channels();
    int lv [4];
    int l, r;
    logic [7:0] b;
    logic       fb;
    for (int c = 0; c < 2; c++) begin
      ftimer[c] -= 2;
      if (ftimer[c] <= 0) begin
        ftimer[c] += (2048 - period[c]) * 4;
        duty_pos[c]++;
      end
    end
    ftimer[2] -= 2;
    if (ftimer[2] <= 0) begin
      ftimer[2] += (2048 - period[2]) * 2;
      wave_pos++;
    end
    ftimer[3] -= 2;
    if (ftimer[3] <= 0) begin
      ftimer[3] += noise_period();
      fb = lfsr[0] ^ lfsr[1];
      lfsr = {fb, lfsr[14:1]};
      if (noise_cfg[3]) lfsr[6] = fb;
    end
    seq_cnt += 2;
    if (seq_cnt >= 8192) begin
      seq_cnt -= 8192;
      case (seq_step)
        3'd0, 3'd4: length_tick();
        3'd2, 3'd6: begin
          length_tick();
          sweep_tick();
        end
        3'd7: envelope_tick();
        default: ;
      endcase
      seq_step++;
    end
    lv = '{0, 0, 0, 0};
    for (int c = 0; c < 2; c++)
      if (active[c] && dac[c] && DUTY_WAVE[duty_sel[c]][duty_pos[c]]) lv[c] = env_lvl[c];
    if (active[2] && dac[2] && wave_vol != 0) begin
      b = wram[wave_pos[4:1]];
      lv[2] = (wave_pos[0] ? b[3:0] : b[7:4]) >> (wave_vol - 1);
    end
    if (active[3] && dac[3] && !lfsr[0]) lv[3] = env_lvl[2];
    l = 0;
    r = 0;
    for (int c = 0; c < 4; c++) begin
      if (regs[IDX_NR51][4 + c]) l += lv[c];
      if (regs[IDX_NR51][c]) r += lv[c];
    end
    lsum = lsum + l > SUM_MAX ? SUM_MAX : lsum + l;
    rsum = rsum + r > SUM_MAX ? SUM_MAX : rsum + r;
  endfunction

  function automatic logic [15:0] side_level(longint sum, int vol);
    longint x;
    x = (sum / ticks) * vol * 46;
    return x > 32767 ? 16'h7FFF : x[15:0];
  endfunction

  function automatic void tick_item();
    longint p;
    apu_result_t res;
    if (pwr) run_channels();
    if (ticks < 16'hFFFF) ticks++;
    p = phase + 2 * out_rate;
    if (p >= clk_rate) begin
      p -= clk_rate;
      phase = p > 24'hFFFFFF ? 24'hFFFFFF : p;
      res.is_sample = 1'b1;
      res.rd        = '0;
      res.left      = side_level(lsum, regs[IDX_NR50][6:4] + 1);
      res.right     = side_level(rsum, regs[IDX_NR50][2:0] + 1);
      result_q.push_back(res);
      lsum = 0;
      rsum = 0;
      ticks = 0;
    end else begin
      phase = p > 24'hFFFFFF ? 24'hFFFFFF : p;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    apu_result_t want;
    apu_result_t res;
    if (!rst_ni) begin
      clear_core();
      for (int i = 0; i < NUM_WAVE; i++) wram[i] = '0;
      out_rate = SAMPLE_RATE_RST;
      clk_rate = CPU_CLOCK_RST;
      result_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SAMPLE_RATE) out_rate = cfg_data_i[16:0];
        else if (cfg_index_i == CFG_CPU_CLOCK) clk_rate = cfg_data_i;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          KIND_TICK: tick_item();
          KIND_READ: begin
            res.is_sample = 1'b0;
            res.rd        = reg_read(in_ch.address);
            res.left      = '0;
            res.right     = '0;
            result_q.push_back(res);
          end
          KIND_WRITE: reg_write(in_ch.address, in_ch.write_data);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected item kind=%0b rd=%h l=%0d r=%0d", $time,
                   out_ch.result_kind, out_ch.read_data, out_ch.left_sample,
                   out_ch.right_sample);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.result_kind !== want.is_sample || out_ch.read_data !== want.rd ||
              out_ch.left_sample !== want.left || out_ch.right_sample !== want.right) begin
            $display("%0t: mismatch expected kind=%0b rd=%h l=%0d r=%0d", $time,
                     want.is_sample, want.rd, want.left, want.right);
            $display("%0t:          actual   kind=%0b rd=%h l=%0d r=%0d", $time,
                     out_ch.result_kind, out_ch.read_data, out_ch.left_sample,
                     out_ch.right_sample);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/dmg_sound_unit_emulation_test.sv =====
// Top of the sound unit testbench: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module dmg_sound_unit_emulation_test;
  import dmg_pkg::*;

  // A sampled tick runs the divider twice; allow a wide margin over the
  // slowest legal run including the long receiver hold.
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fail_count;
  int          pending;
  int          src_idle;
  int          snk_idle;
  logic        hold_req;
  int          cycles;

  dmg_in_if  in_if ();
  dmg_out_if out_if ();

  dmg_sound_unit_emulation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dmg_sound_unit_emulation_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold on request so the
  // output register and the input path back up while the sender keeps going.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(99) >= snk_idle;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // between back-to-back items; it drops only for an idle gap.
  task automatic push_item(logic [1:0] k, logic [15:0] a, logic [7:0] d);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.address    <= a;
    in_if.write_data <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic reg_wr(logic [15:0] a, logic [7:0] d);
    push_item(KIND_WRITE, a, d);
  endtask

  // Drain all results, let a sample-less tick finish, then write a rate.
  task automatic set_rate(logic [1:0] idx, logic [23:0] val);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Bring one channel up with random content and trigger it.
  task automatic start_voice();
    int ch;
    ch = $urandom_range(3);
    reg_wr(16'hFF24, $urandom);
    reg_wr(16'hFF25, $urandom);
    case (ch)
      0: begin
        reg_wr(16'hFF10, $urandom);
        reg_wr(16'hFF11, $urandom);
        reg_wr(16'hFF12, {$urandom_range(15, 1), 4'($urandom)});
        reg_wr(16'hFF13, $urandom);
        reg_wr(16'hFF14, {1'b1, 7'($urandom)});
      end
      1: begin
        reg_wr(16'hFF16, $urandom);
        reg_wr(16'hFF17, {$urandom_range(15, 1), 4'($urandom)});
        reg_wr(16'hFF18, $urandom);
        reg_wr(16'hFF19, {1'b1, 7'($urandom)});
      end
      2: begin
        reg_wr(16'hFF30 + $urandom_range(15), $urandom);
        reg_wr(16'hFF1A, 8'h80);
        reg_wr(16'hFF1B, $urandom);
        reg_wr(16'hFF1C, $urandom);
        reg_wr(16'hFF1D, $urandom);
        reg_wr(16'hFF1E, {1'b1, 7'($urandom)});
      end
      default: begin
        reg_wr(16'hFF20, $urandom);
        reg_wr(16'hFF21, {$urandom_range(15, 1), 4'($urandom)});
        reg_wr(16'hFF22, {$urandom_range(3), 4'($urandom)});
        reg_wr(16'hFF23, {1'b1, 7'($urandom)});
      end
    endcase
  endtask

  // One random step: mostly ticks and voice setups, some reads and raw
  // register writes, a little noise (foreign addresses, unknown kind, power).
  task automatic random_step();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) push_item(KIND_TICK, $urandom, $urandom);
    else if (sel < 60) start_voice();
    else if (sel < 72) push_item(KIND_READ, 16'hFF10 + $urandom_range(47), $urandom);
    else if (sel < 90) reg_wr(16'hFF10 + $urandom_range(47), $urandom);
    else if (sel < 93) push_item(KIND_READ, $urandom, $urandom);
    else if (sel < 95) reg_wr($urandom, $urandom);
    else if (sel < 97) push_item(2'd3, $urandom, $urandom);
    else if (sel < 98) reg_wr(16'hFF26, 8'h00);
    else reg_wr(16'hFF26, 8'h80);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_TICK;
    in_if.address    = '0;
    in_if.write_data = '0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_SAMPLE_RATE;
    cfg_data         = '0;
    src_idle         = 0;
    snk_idle         = 0;
    hold_req         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: foreign addresses, unknown kind, pulse 1, wave and noise, sweep
    // overflow at trigger, unused and power registers, power off and on.
    push_item(KIND_READ, 16'h0000, 8'h00);
    push_item(KIND_READ, 16'hFFFF, 8'hFF);
    push_item(2'd3, 16'hFFFF, 8'hFF);
    reg_wr(16'hFF24, 8'h77);
    reg_wr(16'hFF25, 8'hFF);
    reg_wr(16'hFF10, 8'h11);
    reg_wr(16'hFF12, 8'hF0);
    reg_wr(16'hFF13, 8'hFF);
    reg_wr(16'hFF14, 8'hC7);
    reg_wr(16'hFF30, 8'hF0);
    reg_wr(16'hFF1A, 8'h80);
    reg_wr(16'hFF1C, 8'h20);
    reg_wr(16'hFF1E, 8'h80);
    reg_wr(16'hFF21, 8'hF8);
    reg_wr(16'hFF23, 8'h80);
    push_item(KIND_READ, 16'hFF26, 8'h00);
    push_item(KIND_READ, 16'hFF15, 8'h00);
    repeat (4) push_item(KIND_TICK, 16'h0000, 8'h00);
    reg_wr(16'hFF26, 8'h00);
    reg_wr(16'hFF12, 8'hFF);
    reg_wr(16'hFF3F, 8'hA5);
    push_item(KIND_READ, 16'hFF3F, 8'h00);
    push_item(KIND_READ, 16'hFF26, 8'h00);
    reg_wr(16'hFF26, 8'hFF);

    // Long receiver hold while reads keep coming.
    hold_req = 1'b1;
    repeat (30) push_item(KIND_READ, 16'hFF10 + $urandom_range(47), 8'h00);

    src_idle = 31;
    snk_idle = 85;
    repeat (200) random_step();

    set_rate(CFG_SAMPLE_RATE, 24'd96000);
    set_rate(CFG_CPU_CLOCK, 24'd1000000);
    src_idle = 85;
    snk_idle = 31;
    repeat (200) random_step();

    // Extreme rates: a sample on every tick.
    set_rate(CFG_SAMPLE_RATE, 24'h1FFFF);
    set_rate(CFG_CPU_CLOCK, 24'd0);
    src_idle = 0;
    snk_idle = 0;
    repeat (200) random_step();

    // Slow rates with long tick runs so the frame sequencer steps lengths,
    // sweeps and envelopes.
    set_rate(CFG_SAMPLE_RATE, 24'd8000);
    set_rate(CFG_CPU_CLOCK, 24'd8388608);
    reg_wr(16'hFF26, 8'h80);
    for (int i = 0; i < 40; i++) begin
      start_voice();
      repeat (500) push_item(KIND_TICK, 16'h0000, 8'h00);
      push_item(KIND_READ, 16'hFF26, 8'h00);
    end

    // Zero sample rate: ticks that never emit.
    set_rate(CFG_SAMPLE_RATE, 24'd0);
    set_rate(CFG_CPU_CLOCK, 24'hFFFFFF);
    repeat (20) push_item(KIND_TICK, 16'h0000, 8'h00);
    push_item(KIND_READ, 16'hFF24, 8'h00);
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dmg_pkg.sv
hw/rtl/dmg_if.sv
hw/rtl/dmg_div.sv
hw/rtl/dmg_ctrl.sv
hw/rtl/dmg_datapath.sv
hw/rtl/dmg_sound_unit_emulation.sv
tb/dmg_sound_unit_emulation_checker.sv
tb/dmg_sound_unit_emulation_test.sv
